// ----- rtl/mfh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfh_pkg - shared types and constants of the mesh entity hash
// Entity kind codes, FNV-1a constants, and the words moved between stages.
// ----------------------------------------------------------------------------
package mfh_pkg;

   localparam int unsigned IDX_W       = 64;
   localparam int unsigned IDX_COUNT   = 4;
   localparam int unsigned HASH_W      = 64;
   localparam int unsigned DATA_W      = IDX_W * IDX_COUNT;
   localparam int unsigned HASH_CELLS  = DATA_W / 8;
   localparam int unsigned COUNT_W     = $clog2(HASH_CELLS + 1);
   localparam int unsigned SORT_STEPS  = 6;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_EDGE  = 2'd1;
   localparam logic [1:0] KIND_FACE  = 2'd2;

   localparam logic [HASH_W-1:0] MIX_SEED  = 64'hcbf2_9ce4_8422_2325;
   localparam logic [HASH_W-1:0] MIX_PRIME = 64'h0000_0100_0000_01b3;
   // prime = 2^PRIME_SHIFT + PRIME_LOW
   localparam int unsigned       PRIME_SHIFT   = 40;
   localparam int unsigned       PRIME_LOW_W   = 9;
   localparam logic [PRIME_LOW_W-1:0] PRIME_LOW = MIX_PRIME[PRIME_LOW_W-1:0];

   localparam logic [COUNT_W-1:0] BYTES_EDGE      = COUNT_W'(2 * IDX_W / 8);
   localparam logic [COUNT_W-1:0] BYTES_FACE      = COUNT_W'(4 * IDX_W / 8);
   localparam logic [COUNT_W-1:0] BYTES_FACE_SKIP = COUNT_W'(3 * IDX_W / 8);

   typedef struct packed {
      logic [1:0]                      kind;
      logic [IDX_COUNT-1:0][IDX_W-1:0] idx;   // idx[0] = index_a
   } mfh_sort_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [DATA_W-1:0]  data;    // next byte to fold in bits [7:0]
      logic [COUNT_W-1:0] count;   // bytes still to fold
   } mfh_hash_type;

   // Only bit 1 is decoded for faces, so code three hashes as a face.
   function automatic logic is_face(input logic [1:0] kind);
      return kind[1];
   endfunction

   // Compare-exchange sequence of the four-input network: pair (p, p+1).
   function automatic int unsigned sort_pair(input int unsigned step);
      int unsigned p;
      p = 0;
      unique case (step)
         0: p = 0;
         1: p = 1;
         2: p = 2;
         3: p = 0;
         4: p = 1;
         default: p = 0;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mfh_sort_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfh_sort_cell - one compare-exchange step of the index sort
// Orders the pair (POS, POS+1) by signed compare; edges only use pair 0.
// ----------------------------------------------------------------------------
module mfh_sort_cell #(
   parameter int unsigned POS = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire mfh_pkg::mfh_sort_type up_data,
   output logic                      dn_valid,
   input  wire logic                 dn_ready,
   output mfh_pkg::mfh_sort_type     dn_data
);
   import mfh_pkg::*;

   localparam logic [1:0] LO_SEL    = 2'(POS);
   localparam logic [1:0] HI_SEL    = 2'(POS + 1);
   localparam logic       EDGE_TOO  = (POS == 0);

   logic         valid_ff;
   logic         valid_in;
   mfh_sort_type data_ff;
   mfh_sort_type data_in;
   logic         active;
   logic         swap;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_valid;

   always_comb begin
      active  = is_face(up_data.kind) || (EDGE_TOO && (up_data.kind == KIND_EDGE));
      swap    = active && ($signed(up_data.idx[HI_SEL]) < $signed(up_data.idx[LO_SEL]));
      data_in = up_data;
      if (swap) begin
         data_in.idx[LO_SEL] = up_data.idx[HI_SEL];
         data_in.idx[HI_SEL] = up_data.idx[LO_SEL];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/mfh_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfh_pack - turns sorted indices into a byte stream for the hash cells
// Picks start hash, byte string and byte count per entity kind.
// ----------------------------------------------------------------------------
module mfh_pack (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [63:0]           unused_index,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire mfh_pkg::mfh_sort_type up_data,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output mfh_pkg::mfh_hash_type      dn_data
);
   import mfh_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   mfh_hash_type data_ff;
   mfh_hash_type data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_valid;

   always_comb begin
      data_in.hash  = MIX_SEED;
      data_in.data  = up_data.idx;
      data_in.count = BYTES_FACE;
      priority if (is_face(up_data.kind)) begin
         // smallest index equal to the marker is left out
         if (up_data.idx[0] == unused_index) begin
            data_in.data  = {{IDX_W{1'b0}}, up_data.idx[3], up_data.idx[2], up_data.idx[1]};
            data_in.count = BYTES_FACE_SKIP;
         end
      end else if (up_data.kind == KIND_EDGE) begin
         data_in.data  = {{(2 * IDX_W){1'b0}}, up_data.idx[1], up_data.idx[0]};
         data_in.count = BYTES_EDGE;
      end else begin
         // point: hash is the index itself
         data_in.hash  = up_data.idx[0];
         data_in.data  = '0;
         data_in.count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/mfh_hash_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfh_hash_cell - one FNV-1a byte round
// Folds the low byte in while bytes remain, then shifts the string down.
// ----------------------------------------------------------------------------
module mfh_hash_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire mfh_pkg::mfh_hash_type up_data,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output mfh_pkg::mfh_hash_type      dn_data
);
   import mfh_pkg::*;

   logic                            valid_ff;
   logic                            valid_in;
   mfh_hash_type                    data_ff;
   mfh_hash_type                    data_in;
   logic [HASH_W-1:0]               mixed;
   logic [HASH_W+PRIME_LOW_W-1:0]   prod_low;
   logic [HASH_W-1:0]               prod;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_valid;

   // h * prime mod 2^64 = (h << 40) + h * 0x1b3
   always_comb begin
      mixed    = up_data.hash ^ {{(HASH_W-8){1'b0}}, up_data.data[7:0]};
      prod_low = {{PRIME_LOW_W{1'b0}}, mixed} * {{HASH_W{1'b0}}, PRIME_LOW};
      prod     = (mixed << PRIME_SHIFT) + prod_low[HASH_W-1:0];
      data_in  = up_data;
      if (up_data.count != '0) begin
         data_in.hash  = prod;
         data_in.data  = {8'h00, up_data.data[DATA_W-1:8]};
         data_in.count = up_data.count - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/mesh_entity_fnv1a_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_entity_fnv1a_hash - order-independent FNV-1a hash of a mesh entity
// Sort network, byte packer and a row of 32 byte-round cells.
// ----------------------------------------------------------------------------
// Use:
//   req_ channel carries one entity per word: kind in tuser (0 point,
//   1 edge, 2 or 3 face) and four signed 64-bit vertex indices in tdata.
//   rsp_ channel returns one 64-bit hash word per entity, in order.
//   csr_wr_en/csr_wr_data set the absent-vertex marker; write it only
//   while the block holds no entity.
// Path: an accepted entity passes 6 compare-exchange cells, 1 pack stage
//   and 32 byte-round cells on its way to rsp_tvalid.
// Throughput: one entity per cycle unless rsp_tready holds the pipe; each stage is its own register slice,
//   one FNV byte round (xor, shift-add with a 64x9 multiply) per cell.
// Stalls: every stage is ready when empty or when its successor takes its
//   word, so bubbles close up and new entities enter while a finished hash
//   waits on rsp_tready. A full pipe holds 39 entities.
// Reset: empties every stage and sets the marker to all ones (-1).
// ----------------------------------------------------------------------------
module mesh_entity_fnv1a_hash (
   input  wire logic         clock,
   input  wire logic         reset,
   // configuration
   input  wire logic         csr_wr_en,
   input  wire logic [63:0]  csr_wr_data,   // unused_index
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [255:0] req_tdata,     // index_a, index_b, index_c, index_d
   input  wire logic [1:0]   req_tuser,     // req_type
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata      // hash_value
);
   import mfh_pkg::*;

   logic [IDX_W-1:0] unused_ff;
   logic [IDX_W-1:0] unused_in;

   // sort chain: slot 0 is the request port, slot SORT_STEPS feeds the packer
   logic         sort_valid [SORT_STEPS+1];
   logic         sort_ready [SORT_STEPS+1];
   mfh_sort_type sort_data  [SORT_STEPS+1];

   // hash chain: slot 0 is the packer output, last slot the response port
   logic         hash_valid [HASH_CELLS+1];
   logic         hash_ready [HASH_CELLS+1];
   mfh_hash_type hash_data  [HASH_CELLS+1];

   // marker register
   assign unused_in = csr_wr_en ? csr_wr_data : unused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unused_ff <= '1;
      end else begin
         unused_ff <= unused_in;
      end
   end

   assign sort_valid[0]     = req_tvalid;
   assign req_tready        = sort_ready[0];
   assign sort_data[0].kind = req_tuser;
   assign sort_data[0].idx  = req_tdata;

   // exchange pairs (0,1) (1,2) (2,3) (0,1) (1,2) (0,1)
   for (genvar i = 0; i < SORT_STEPS; i++) begin : g_sort
      mfh_sort_cell #(
         .POS (sort_pair(i))
      ) u_sort (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sort_valid[i]),
         .up_ready (sort_ready[i]),
         .up_data  (sort_data[i]),
         .dn_valid (sort_valid[i+1]),
         .dn_ready (sort_ready[i+1]),
         .dn_data  (sort_data[i+1])
      );
   end

   mfh_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .unused_index (unused_ff),
      .up_valid     (sort_valid[SORT_STEPS]),
      .up_ready     (sort_ready[SORT_STEPS]),
      .up_data      (sort_data[SORT_STEPS]),
      .dn_valid     (hash_valid[0]),
      .dn_ready     (hash_ready[0]),
      .dn_data      (hash_data[0])
   );

   // one byte round per cell; cells past the entity's length pass it on
   for (genvar j = 0; j < HASH_CELLS; j++) begin : g_hash
      mfh_hash_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (hash_valid[j]),
         .up_ready (hash_ready[j]),
         .up_data  (hash_data[j]),
         .dn_valid (hash_valid[j+1]),
         .dn_ready (hash_ready[j+1]),
         .dn_data  (hash_data[j+1])
      );
   end

   assign rsp_tvalid             = hash_valid[HASH_CELLS];
   assign hash_ready[HASH_CELLS] = rsp_tready;
   assign rsp_tdata              = hash_data[HASH_CELLS].hash;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for mesh_entity_fnv1a_hash
// Drives points, edges and faces through the request stream and compares
// every hash word against an order-independent FNV-1a predictor, under
// random idling on both streams, a long response hold-off and a series of
// absent-vertex marker settings.
// ----------------------------------------------------------------------------

// Keeps the marker and the queue of hashes still owed by the block.
class hash_scoreboard;
   logic [63:0] marker;
   logic [63:0] owed_hashes[$];
   int unsigned failures;

   function new();
      marker   = '1;
      failures = 0;
   endfunction

   // One FNV-1a round per byte, low byte first.
   function logic [63:0] fold_index(input logic [63:0] h, input logic [63:0] v);
      for (int k = 0; k < 8; k++) begin
         h = h ^ {56'd0, v[8*k +: 8]};
         h = h * mfh_pkg::MIX_PRIME;
      end
      return h;
   endfunction

   function logic [63:0] entity_hash(input logic [1:0] kind, input logic [63:0] a,
                                     input logic [63:0] b, input logic [63:0] c,
                                     input logic [63:0] d);
      logic signed [63:0] v[4];
      logic signed [63:0] t;
      logic [63:0]        h;
      v = '{a, b, c, d};
      h = mfh_pkg::MIX_SEED;
      if (kind[1]) begin
         // faces: code 2 and the undecoded code 3 alike
         for (int p = 0; p < 3; p++)
            for (int j = 0; j < 3 - p; j++)
               if (v[j+1] < v[j]) begin
                  t      = v[j];
                  v[j]   = v[j+1];
                  v[j+1] = t;
               end
         if (v[0] != marker)
            h = fold_index(h, v[0]);
         for (int j = 1; j < 4; j++)
            h = fold_index(h, v[j]);
      end else if (kind == mfh_pkg::KIND_EDGE) begin
         if (v[1] < v[0]) begin
            t    = v[0];
            v[0] = v[1];
            v[1] = t;
         end
         h = fold_index(fold_index(h, v[0]), v[1]);
      end else begin
         h = a;
      end
      return h;
   endfunction

   function void note_entity(input logic [1:0] kind, input logic [63:0] a,
                             input logic [63:0] b, input logic [63:0] c,
                             input logic [63:0] d);
      owed_hashes.insert(owed_hashes.size(), entity_hash(kind, a, b, c, d));
   endfunction

   function void check_hash(input logic [63:0] got);
      logic [63:0] want;
      if (owed_hashes.size() == 0) begin
         $error("hash_value: expected none, actual %h", got);
         failures++;
      end else begin
         want = owed_hashes.pop_front();
         if (got !== want) begin
            $error("hash_value: expected %h, actual %h", want, got);
            failures++;
         end
      end
   endfunction

   function int unsigned pending();
      return owed_hashes.size();
   endfunction
endclass

module testbench;
   import mfh_pkg::*;

   // code 3 is decoded as a face by the block
   localparam logic [1:0]  KIND_FACE_ALT  = 2'd3;
   localparam logic [63:0] IDX_MIN        = 64'h8000_0000_0000_0000;
   localparam logic [63:0] IDX_MAX        = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] IDX_NEG_ONE    = '1;
   // quiet cycles allowed: the HOLD_OFF_LEN hold-off plus ample margin
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          HOLD_OFF_LEN   = 300;
   localparam int          PIPE_DRAIN     = 48;
   localparam int          PHASE_WORDS    = 88;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         csr_wr_en   = 1'b0;
   logic [63:0]  csr_wr_data = '0;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata   = '0;
   logic [1:0]   req_tuser   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [63:0]  rsp_tdata;

   hash_scoreboard sb = new();

   bit calm;           // last phase: no idling on either side
   bit hold_off_req;   // asks the receiver for one long stall
   int quiet_cycles;

   always #4 clock = ~clock;

   mesh_entity_fnv1a_hash u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Response checking and watchdog. Values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_hash(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random ready and stall bursts, one long hold-off on request,
   // always ready in the calm phase.
   initial begin : receiver
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Offer one word and hold it until the block takes it.
   task automatic send_entity(input logic [1:0] kind, input logic [63:0] a,
                              input logic [63:0] b, input logic [63:0] c,
                              input logic [63:0] d);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {d, c, b, a};
      do @(posedge clock); while (!req_tready);
      sb.note_entity(kind, a, b, c, d);
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender stays quiet until every owed hash has come back.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Marker write, only ever with the pipe empty.
   task automatic write_marker(input logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.marker = value;
   endtask

   // Index mix: corners, small values, the marker, full-range random.
   function automatic logic [63:0] pick_index();
      logic signed [63:0] s;
      logic [63:0]        corner[5];
      corner = '{IDX_MIN, IDX_MAX, 64'd0, 64'd1, IDX_NEG_ONE};
      case ($urandom_range(0, 9))
         0: begin
            s = 64'($urandom_range(0, 8));
            return s - 64'sd4;
         end
         1: return corner[$urandom_range(0, 4)];
         2: return sb.marker;
         3: return 64'($urandom_range(0, 1000));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send_random_entity(input bit gaps);
      logic [1:0]  kind;
      logic [63:0] v[4];
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)      kind = KIND_POINT;
      else if (pick < 5) kind = KIND_EDGE;
      else if (pick < 9) kind = KIND_FACE;
      else               kind = KIND_FACE_ALT;
      foreach (v[i]) v[i] = pick_index();
      // triangles: marker in a random slot
      if (kind[1] && $urandom_range(0, 2) == 0)
         v[$urandom_range(0, 3)] = sb.marker;
      // repeated vertices
      if ($urandom_range(0, 4) == 0)
         v[$urandom_range(0, 3)] = v[$urandom_range(0, 3)];
      if (gaps && !calm && $urandom_range(0, 5) == 0)
         pause_sender($urandom_range(1, 15));
      send_entity(kind, v[0], v[1], v[2], v[3]);
   endtask

   initial begin : stimulus
      logic [63:0] phase_marker[6];

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed words, reset marker (all ones) ---
      // points: extremes, other indices are don't-care
      send_entity(KIND_POINT, 64'd0, IDX_MAX, IDX_MIN, 64'd5);
      send_entity(KIND_POINT, IDX_MIN, 64'd1, 64'd2, 64'd3);
      send_entity(KIND_POINT, IDX_MAX, '0, '0, '0);
      send_entity(KIND_POINT, IDX_NEG_ONE, IDX_NEG_ONE, 64'd9, 64'd9);
      // edges in both orders, extremes, equal pair, c and d ignored
      send_entity(KIND_EDGE, 64'd5, 64'd3, IDX_MAX, IDX_MIN);
      send_entity(KIND_EDGE, 64'd3, 64'd5, 64'd0, 64'd0);
      send_entity(KIND_EDGE, IDX_MIN, IDX_MAX, 64'd1, 64'd1);
      send_entity(KIND_EDGE, IDX_MAX, IDX_MIN, 64'd2, 64'd2);
      send_entity(KIND_EDGE, IDX_NEG_ONE, 64'd1, 64'd7, 64'd7);
      send_entity(KIND_EDGE, 64'd7, 64'd7, IDX_NEG_ONE, 64'd0);
      // faces
      send_entity(KIND_FACE, 64'd4, 64'd3, 64'd2, 64'd1);
      send_entity(KIND_FACE, IDX_MIN, IDX_MAX, 64'd0, IDX_NEG_ONE); // marker not lowest
      send_entity(KIND_FACE, 64'd10, 64'd20, 64'd30, IDX_NEG_ONE);  // triangle
      send_entity(KIND_FACE, 64'd30, IDX_NEG_ONE, 64'd10, 64'd20);  // marker elsewhere
      send_entity(KIND_FACE, IDX_NEG_ONE, IDX_NEG_ONE, 64'd5, 64'd6); // marker twice
      send_entity(KIND_FACE, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX);
      send_entity(KIND_FACE, 64'd0, 64'd0, 64'd0, 64'd0);
      send_entity(KIND_FACE, IDX_MIN, IDX_MIN, IDX_MIN, IDX_MIN);
      send_entity(KIND_FACE, -64'sd5, IDX_NEG_ONE, 64'd2, 64'd3);
      // undecoded code 3 behaves as a face
      send_entity(KIND_FACE_ALT, 64'd9, 64'd8, 64'd7, 64'd6);
      send_entity(KIND_FACE_ALT, 64'd3, 64'd2, 64'd1, IDX_NEG_ONE);
      send_entity(KIND_FACE_ALT, IDX_MAX, IDX_MIN, IDX_NEG_ONE, 64'd0);

      // --- random phases, one marker each; the last returns to all ones ---
      phase_marker = '{64'd0, IDX_MIN, IDX_MAX, {$urandom(), $urandom()},
                       64'd3, IDX_NEG_ONE};
      foreach (phase_marker[p]) begin
         drain_pipe();
         write_marker(phase_marker[p]);
         if (p == 1) begin
            // long receiver stall while words keep coming: pipe fills, input stalls
            hold_off_req = 1'b1;
            repeat (80) send_random_entity(1'b0);
            repeat (PHASE_WORDS - 80) send_random_entity(1'b1);
         end else begin
            calm = (p == 5);
            repeat (PHASE_WORDS) send_random_entity(1'b1);
         end
      end

      drain_pipe();
      repeat (PIPE_DRAIN) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("hash_value: expected %0d more words, actual none", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
